FILE: hdl/tpfifo_pkg.sv
// Shared types and constants for the two-class strict-priority descriptor FIFO.
// No dependencies; used by tpfifo_queue and two_class_priority_fifo_unit.
`default_nettype none

package tpfifo_pkg;

    // Default geometry
    localparam int QUEUE_DEPTH_DEF     = 1024;
    localparam int DESCRIPTOR_BITS_DEF = 16;

    // Configuration port
    localparam int CFG_W      = 11;
    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_W-1:0] LIMIT_RESET = CFG_W'(1024);

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_HIGH_LIMIT   = 2'd0,
        REG_NORMAL_LIMIT = 2'd1
    } cfg_reg_t;

    // Operation code carried in s_tuser[0]
    typedef enum logic {
        FUNC_PUSH = 1'b0,
        FUNC_POP  = 1'b1
    } func_t;

    // Bit positions in the user sidebands
    localparam int S_USER_FUNC  = 0;
    localparam int S_USER_CLASS = 1;
    localparam int M_USER_DONE  = 0;
    localparam int M_USER_HIGH  = 1;

    // Per-queue control and status between the top level and a queue
    typedef struct packed {
        logic push;
        logic pop;
    } queue_ctl_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

`default_nettype wire

FILE: hdl/tpfifo_queue.sv
// One descriptor FIFO: storage array, read/write pointers, fill count and limit check.
// Depends on tpfifo_pkg.
`default_nettype none

module tpfifo_queue #(
    parameter int QUEUE_DEPTH     = tpfifo_pkg::QUEUE_DEPTH_DEF,
    parameter int DESCRIPTOR_BITS = tpfifo_pkg::DESCRIPTOR_BITS_DEF,
    localparam int LVL_W          = $clog2(QUEUE_DEPTH + 1)
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire [tpfifo_pkg::CFG_W-1:0]  limit,
    input  wire tpfifo_pkg::queue_ctl_t  ctl,
    input  wire [DESCRIPTOR_BITS-1:0]    push_data,
    output logic [DESCRIPTOR_BITS-1:0]   rd_data,
    output logic [LVL_W-1:0]             level,
    output tpfifo_pkg::queue_status_t    status
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CMP_W = (LVL_W > tpfifo_pkg::CFG_W) ? LVL_W : tpfifo_pkg::CFG_W;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    logic [DESCRIPTOR_BITS-1:0] mem [QUEUE_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0] count_reg,  count_next;
    logic [CMP_W-1:0] lim_eff;

    // Saturate the limit at the physical depth
    always_comb begin
        if (CMP_W'(limit) > CMP_W'(QUEUE_DEPTH)) begin
            lim_eff = CMP_W'(QUEUE_DEPTH);
        end else begin
            lim_eff = CMP_W'(limit);
        end
    end

    assign status.full  = (CMP_W'(count_reg) >= lim_eff);
    assign status.empty = (count_reg == '0);
    assign level        = count_reg;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (ctl.push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            count_next  = count_reg + 1'b1;
        end else if (ctl.pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            count_next  = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (ctl.push) begin
            mem[wr_ptr_reg] <= push_data;
        end
        if (ctl.pop) begin
            rd_data <= mem[rd_ptr_reg];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/two_class_priority_fifo_unit.sv
// Two-class strict-priority descriptor FIFO, top level.
// Depends on tpfifo_pkg and tpfifo_queue.
`default_nettype none

// Channel   | Dir | tdata (low bit up)                           | tuser (low bit up)
// ----------+-----+----------------------------------------------+--------------------------
// s_ (op)   | in  | descriptor_in                                | func, high_class
// m_ (res)  | out | descriptor_out, high_level, normal_level     | done_res, came_from_high
// cfg_      | in  | cfg_addr 0 high_limit, 1 normal_limit        | -
//
// One transaction per cycle while the result side is not stalled: the push/pop decision,
// pointer and count update and the storage access all happen at the edge that accepts
// the operation; the result is valid the next cycle, with a popped descriptor taken from
// the registered read port of its queue.
// Reset (aresetn low, synchronous) empties both queues and sets both limits to 1024.
// The result register holds while m_tready is low; s_tready then drops, so a stall
// on the result side stalls the operation side in the same cycle.

module two_class_priority_fifo_unit #(
    parameter int QUEUE_DEPTH     = tpfifo_pkg::QUEUE_DEPTH_DEF,
    parameter int DESCRIPTOR_BITS = tpfifo_pkg::DESCRIPTOR_BITS_DEF,
    localparam int LVL_W          = $clog2(QUEUE_DEPTH + 1),
    localparam int S_TDATA_W      = ((DESCRIPTOR_BITS + 7) / 8) * 8,
    localparam int M_TDATA_W      = ((DESCRIPTOR_BITS + 2 * LVL_W + 7) / 8) * 8
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    // operation channel
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire [S_TDATA_W-1:0]              s_tdata,   // descriptor_in, zero pad
    input  wire [1:0]                        s_tuser,   // func, high_class
    // result channel
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [M_TDATA_W-1:0]             m_tdata,   // descriptor_out, high_level,
                                                        // normal_level, zero pad
    output logic [1:0]                       m_tuser,   // done_res, came_from_high
    // configuration write port
    input  wire                              cfg_wr_en,
    input  wire [tpfifo_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire [tpfifo_pkg::CFG_W-1:0]      cfg_wdata
);

    localparam int PAD_W = M_TDATA_W - DESCRIPTOR_BITS - 2 * LVL_W;

    // Limit registers
    logic [tpfifo_pkg::CFG_W-1:0] high_limit_reg, normal_limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            high_limit_reg   <= tpfifo_pkg::LIMIT_RESET;
            normal_limit_reg <= tpfifo_pkg::LIMIT_RESET;
        end else if (cfg_wr_en) begin
            unique case (tpfifo_pkg::cfg_reg_t'(cfg_addr))
                tpfifo_pkg::REG_HIGH_LIMIT:   high_limit_reg   <= cfg_wdata;
                tpfifo_pkg::REG_NORMAL_LIMIT: normal_limit_reg <= cfg_wdata;
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    // Operation decode
    tpfifo_pkg::queue_ctl_t    high_ctl, normal_ctl;
    tpfifo_pkg::queue_status_t high_st, normal_st;
    logic [DESCRIPTOR_BITS-1:0] high_rd, normal_rd;
    logic [LVL_W-1:0]           high_level, normal_level;

    logic take;
    logic is_pop;
    logic to_high;

    assign s_tready = !m_tvalid || m_tready;
    assign take     = s_tvalid && s_tready;
    assign is_pop   = (tpfifo_pkg::func_t'(s_tuser[tpfifo_pkg::S_USER_FUNC])
                       == tpfifo_pkg::FUNC_POP);
    assign to_high  = s_tuser[tpfifo_pkg::S_USER_CLASS];

    // Push goes to the named class if below its limit; pop serves high first
    always_comb begin
        high_ctl.push   = take && !is_pop &&  to_high && !high_st.full;
        normal_ctl.push = take && !is_pop && !to_high && !normal_st.full;
        high_ctl.pop    = take &&  is_pop && !high_st.empty;
        normal_ctl.pop  = take &&  is_pop &&  high_st.empty && !normal_st.empty;
    end

    tpfifo_queue #(
        .QUEUE_DEPTH     (QUEUE_DEPTH),
        .DESCRIPTOR_BITS (DESCRIPTOR_BITS)
    ) u_high_q (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .limit     (high_limit_reg),
        .ctl       (high_ctl),
        .push_data (s_tdata[DESCRIPTOR_BITS-1:0]),
        .rd_data   (high_rd),
        .level     (high_level),
        .status    (high_st)
    );

    tpfifo_queue #(
        .QUEUE_DEPTH     (QUEUE_DEPTH),
        .DESCRIPTOR_BITS (DESCRIPTOR_BITS)
    ) u_normal_q (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .limit     (normal_limit_reg),
        .ctl       (normal_ctl),
        .push_data (s_tdata[DESCRIPTOR_BITS-1:0]),
        .rd_data   (normal_rd),
        .level     (normal_level),
        .status    (normal_st)
    );

    // Result register. Levels come straight from the queue counters: they only
    // move on an accepted transaction, which also advances this register.
    logic m_valid_reg, m_valid_next;
    logic done_reg, done_next;
    logic pop_high_reg, pop_normal_reg;
    logic [DESCRIPTOR_BITS-1:0] desc_out;

    assign done_next    = high_ctl.push || normal_ctl.push || high_ctl.pop || normal_ctl.pop;
    assign m_valid_next = take ? 1'b1 : (m_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            done_reg       <= 1'b0;
            pop_high_reg   <= 1'b0;
            pop_normal_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (take) begin
                done_reg       <= done_next;
                pop_high_reg   <= high_ctl.pop;
                pop_normal_reg <= normal_ctl.pop;
            end
        end
    end

    // Select the popped descriptor from the queue that served the pop; zero otherwise
    always_comb begin
        if (pop_high_reg) begin
            desc_out = high_rd;
        end else if (pop_normal_reg) begin
            desc_out = normal_rd;
        end else begin
            desc_out = '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, normal_level, high_level, desc_out};
    assign m_tuser  = {pop_high_reg, done_reg};

    // Strict priority: normal is served only when high is empty
    assert property (@(posedge aclk) disable iff (!aresetn)
        normal_ctl.pop |-> high_st.empty)
        else $error("normal queue popped while high queue holds entries");

    // Never pop the high queue while it is empty
    assert property (@(posedge aclk) disable iff (!aresetn)
        high_ctl.pop |-> !high_st.empty)
        else $error("high queue popped while empty");

    // A result from the high queue is always a completed pop
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && pop_high_reg |-> done_reg && !pop_normal_reg)
        else $error("inconsistent pop source in result register");

    // A refused push leaves both levels unchanged
    assert property (@(posedge aclk) disable iff (!aresetn)
        take && !is_pop && !done_next |=>
            high_level == $past(high_level) && normal_level == $past(normal_level))
        else $error("refused push changed a fill level");

    // No operation is accepted while the output stalls
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_tready |=> !take || $past(take) == 1'b0)
        else $error("operation accepted while result stalled");

endmodule

`default_nettype wire
